/* design/paxos_acceptor_slot_table_macros.svh */
// Assertion helpers for the blocks that check themselves.
`ifndef PAXOS_ACCEPTOR_SLOT_TABLE_MACROS_SVH
`define PAXOS_ACCEPTOR_SLOT_TABLE_MACROS_SVH

// Condition in this cycle implies a consequence in the same cycle.
`define PST_ASSERT_SAME(label, clk, rst_n, cond, concl, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (concl)) \
		else $error(msg);

// Condition in this cycle implies a consequence in the next cycle.
`define PST_ASSERT_NEXT(label, clk, rst_n, cond, concl, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (concl)) \
		else $error(msg);

`endif

/* design/pst_pkg.sv */
package pst_pkg;

	localparam int SLOT_COUNT = 1024;
	localparam int KEY_BITS   = 32;

	// Table address width and the number of key bits that are kept.
	localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int KEY_W  = (KEY_BITS < 32) ? KEY_BITS : 32;

	// Depth of the queue between the front and the back.
	localparam int QDEPTH = 2;

	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 136;

	localparam logic ACT_PREPARE = 1'b0;
	localparam logic ACT_ACCEPT  = 1'b1;

	localparam logic REPLY_PROMISE  = 1'b0;
	localparam logic REPLY_ACCEPTED = 1'b1;

	localparam logic [1:0] OP_NOP = 2'd0;

	typedef struct packed {
		logic               action;
		logic [9:0]         slot;
		logic [30:0]        round;
		logic [7:0]         bnode;
		logic [7:0]         sender;
		logic [1:0]         op;
		logic [31:0]        key;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic               pvalid;
		logic [30:0]        pround;
		logic [7:0]         pnode;
		logic               avalid;
		logic [1:0]         aop;
		logic [KEY_W-1:0]   akey;
		logic signed [31:0] avalue;
	} entry_t;

	typedef struct packed {
		logic               kind;
		logic [7:0]         dest;
		logic [7:0]         from_node;
		logic [9:0]         slot;
		logic [30:0]        round;
		logic [7:0]         bnode;
		logic [1:0]         op;
		logic [31:0]        key;
		logic signed [31:0] value;
	} reply_t;

	typedef struct packed {
		logic clearing;
		logic evaluating;
		logic table_upd;
	} bk_stat_t;

endpackage

/* design/pst_ram.sv */
module pst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* design/pst_front.sv */
module pst_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [pst_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [0:0]           s_tuser,
	input  pst_pkg::bk_stat_t    bk_stat,
	output logic                 q_valid,
	output pst_pkg::req_t        q_req,
	input  logic                 q_pop
);

	localparam int QPTR_W = (pst_pkg::QDEPTH > 1) ? $clog2(pst_pkg::QDEPTH) : 1;
	localparam int QCNT_W = $clog2(pst_pkg::QDEPTH + 1);

	pst_pkg::req_t      in_req;
	logic               in_range;
	logic               push;
	logic               accept;
	pst_pkg::req_t      qmem_q [pst_pkg::QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	always_comb begin
		in_req.action = s_tuser[0];
		in_req.slot   = s_tdata[9:0];
		in_req.round  = s_tdata[40:10];
		in_req.bnode  = s_tdata[48:41];
		in_req.sender = s_tdata[56:49];
		in_req.op     = s_tdata[58:57];
		in_req.key    = s_tdata[90:59];
		in_req.value  = s_tdata[122:91];
	end

	// Messages for slots beyond the table are taken and dropped here.
	assign in_range = (32'(in_req.slot) < 32'(pst_pkg::SLOT_COUNT));

	assign s_tready = (count_q != QCNT_W'(pst_pkg::QDEPTH)) && !bk_stat.clearing;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && in_range;

	always_ff @(posedge clk) begin
		if (push) begin
			qmem_q[wr_ptr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(pst_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(pst_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign q_valid = (count_q != '0);
	assign q_req   = qmem_q[rd_ptr_q];

endmodule

/* design/pst_back.sv */
module pst_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  pst_pkg::req_t     q_req,
	output logic              q_pop,
	input  logic [7:0]        node_id,
	input  logic              m_tready,
	output logic              m_tvalid,
	output pst_pkg::reply_t   m_reply,
	output pst_pkg::bk_stat_t bk_stat
);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EVAL  = 3'b100
	} state_t;

	localparam int ENTRY_W = $bits(pst_pkg::entry_t);

	state_t                      state_q;
	logic [pst_pkg::ADDR_W-1:0]  clr_q;
	pst_pkg::req_t               cur_q;
	pst_pkg::reply_t             reply_q;
	logic                        out_valid_q;

	pst_pkg::entry_t             old_ent;
	pst_pkg::entry_t             new_ent;
	logic [ENTRY_W-1:0]          rd_word;
	logic                        below;
	logic                        out_free;
	logic                        load;
	logic                        tbl_wr;
	logic [pst_pkg::ADDR_W-1:0]  tbl_waddr;
	logic [ENTRY_W-1:0]          tbl_wdata;
	pst_pkg::reply_t             reply_d;

	assign old_ent = pst_pkg::entry_t'(rd_word);

	// Ballots order by round, then by proposer node; an empty slot takes any ballot.
	assign below = old_ent.pvalid &&
		((cur_q.round < old_ent.pround) ||
		 ((cur_q.round == old_ent.pround) && (cur_q.bnode < old_ent.pnode)));

	assign out_free = !out_valid_q || m_tready;
	assign load     = (state_q == ST_EVAL) && !below && out_free;
	assign q_pop    = (state_q == ST_IDLE) && q_valid;

	always_comb begin
		new_ent        = old_ent;
		new_ent.pvalid = 1'b1;
		new_ent.pround = cur_q.round;
		new_ent.pnode  = cur_q.bnode;
		if (cur_q.action == pst_pkg::ACT_ACCEPT) begin
			new_ent.avalid = 1'b1;
			new_ent.aop    = cur_q.op;
			new_ent.akey   = cur_q.key[pst_pkg::KEY_W-1:0];
			new_ent.avalue = cur_q.value;
		end
	end

	always_comb begin
		reply_d.kind      = cur_q.action;
		reply_d.dest      = cur_q.sender;
		reply_d.from_node = node_id;
		reply_d.slot      = cur_q.slot;
		reply_d.round     = cur_q.round;
		reply_d.bnode     = cur_q.bnode;
		if (cur_q.action == pst_pkg::ACT_ACCEPT) begin
			reply_d.op    = cur_q.op;
			reply_d.key   = 32'(cur_q.key[pst_pkg::KEY_W-1:0]);
			reply_d.value = cur_q.value;
		end else if (old_ent.avalid) begin
			reply_d.op    = old_ent.aop;
			reply_d.key   = 32'(old_ent.akey);
			reply_d.value = old_ent.avalue;
		end else begin
			reply_d.op    = pst_pkg::OP_NOP;
			reply_d.key   = '0;
			reply_d.value = '0;
		end
	end

	assign tbl_wr    = (state_q == ST_CLEAR) || load;
	assign tbl_waddr = (state_q == ST_CLEAR) ? clr_q : pst_pkg::ADDR_W'(cur_q.slot);
	assign tbl_wdata = (state_q == ST_CLEAR) ? '0 : ENTRY_W'(new_ent);

	pst_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (pst_pkg::SLOT_COUNT)
	) u_table (
		.clk     (clk),
		.wr_en   (tbl_wr),
		.wr_addr (tbl_waddr),
		.wr_data (tbl_wdata),
		.rd_en   (q_pop),
		.rd_addr (pst_pkg::ADDR_W'(q_req.slot)),
		.rd_data (rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == pst_pkg::ADDR_W'(pst_pkg::SLOT_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (below || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_req;
		end
		if (load) begin
			reply_q <= reply_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_reply  = reply_q;

	assign bk_stat.clearing   = (state_q == ST_CLEAR);
	assign bk_stat.evaluating = (state_q == ST_EVAL);
	assign bk_stat.table_upd  = load;

endmodule

/* design/paxos_acceptor_slot_table.sv */
// Multi-Paxos acceptor over a per-slot table of promised ballots and accepted
// commands. Prepare and accept messages enter as words on the s_ stream, and
// PROMISE or ACCEPTED replies leave as words on the m_ stream. A message whose
// ballot is below the slot's promise, or whose slot lies beyond the table,
// produces no reply. The one-register cfg channel sets the node number that is
// stamped into every reply; it is always ready. The user must see that it is
// written only while idle; the block itself does not enforce this. A front
// stage takes words into a two-entry queue; the back stage pops one, reads
// its table entry (registered memory read) and then, in its evaluation state,
// updates the entry and loads the reply register once the output register is
// free. The back stage takes no new word until it is through with the current
// one. After reset the table is cleared one slot per cycle, so no word is
// accepted until the clearing pass is done. When the receiver stalls, the
// held reply stays in its register, the back stage waits with the next
// result, and the front keeps filling the queue until it is full.
module paxos_acceptor_slot_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [7:0]                     cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// slot[9:0], ballot_round[40:10], ballot_node[48:41], sender_node[56:49],
	// cmd_op[58:57], cmd_key[90:59], cmd_value[122:91], zeros above.
	input  logic [pst_pkg::IN_DATA_W-1:0]  s_tdata,
	// action[0].
	input  logic [0:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// dest_node[7:0], from_node[15:8], reply_slot[25:16], reply_round[56:26],
	// reply_ballot_node[64:57], reply_op[66:65], reply_key[98:67],
	// reply_value[130:99], zeros above.
	output logic [pst_pkg::OUT_DATA_W-1:0] m_tdata,
	// reply_kind[0].
	output logic [0:0]                     m_tuser
);

	`include "paxos_acceptor_slot_table_macros.svh"

	logic              [7:0] node_id_q;
	logic                    q_valid;
	pst_pkg::req_t           q_req;
	logic                    q_pop;
	pst_pkg::reply_t         reply;
	pst_pkg::bk_stat_t       bk_stat;

	// The node number register takes every write at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			node_id_q <= cfg_data;
		end
	end

	pst_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.bk_stat  (bk_stat),
		.q_valid  (q_valid),
		.q_req    (q_req),
		.q_pop    (q_pop)
	);

	pst_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_req    (q_req),
		.q_pop    (q_pop),
		.node_id  (node_id_q),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_reply  (reply),
		.bk_stat  (bk_stat)
	);

	// Pack the reply register onto the output stream.
	assign m_tuser[0] = reply.kind;
	assign m_tdata    = {5'b0, reply.value, reply.key, reply.op, reply.bnode,
		reply.round, reply.slot, reply.from_node, reply.dest};

	// A reply can only be loaded while the back stage is evaluating an entry.
	`PST_ASSERT_SAME(a_upd_in_eval, clk, arst_n, bk_stat.table_upd, bk_stat.evaluating,
		"table update outside the evaluation step")

	// An update must never overwrite a reply that the receiver still holds back.
	`PST_ASSERT_SAME(a_upd_no_clobber, clk, arst_n, bk_stat.table_upd,
		!m_tvalid || m_tready, "reply register overwritten while stalled")

	// Every table update shows up as a valid reply in the next cycle.
	`PST_ASSERT_NEXT(a_upd_gives_reply, clk, arst_n, bk_stat.table_upd, m_tvalid,
		"table update without a reply")

	// No reply can exist while the table is still being cleared.
	`PST_ASSERT_SAME(a_no_reply_clear, clk, arst_n, bk_stat.clearing, !m_tvalid,
		"reply during the clearing pass")

endmodule
